// File: design/vfc_pkg.sv
package vfc_pkg;

    localparam int VALUE_W = 32;
    localparam int OCC_W   = 7;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      last_item;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] distinct_value;
        logic        [OCC_W-1:0]   occurrences;
        logic                      last_run;
        logic                      overflowed;
    } out_word_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_flags_t;

endpackage

// File: design/vfc_store.sv
module vfc_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [vfc_pkg::VALUE_W-1:0]    wr_data,
    input  logic                           rd_en,
    input  logic [AW-1:0]                  rd_addr,
    output logic [vfc_pkg::VALUE_W-1:0]    rd_data
);

    logic [vfc_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [vfc_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/vfc_cmp.sv
module vfc_cmp (
    input  logic signed [vfc_pkg::VALUE_W-1:0] a,
    input  logic signed [vfc_pkg::VALUE_W-1:0] b,
    output vfc_pkg::cmp_flags_t                flags
);

    always_comb begin
        flags.gt = (a > b);
        flags.eq = (a == b);
    end

endmodule

// File: design/vfc_ctrl.sv
module vfc_ctrl #(
    parameter int MAX_ITEMS = 64,
    parameter int AW        = 6,
    parameter int CW        = 7
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  vfc_pkg::in_word_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output vfc_pkg::out_word_t             m_data,
    output logic                           wr_en,
    output logic [AW-1:0]                  wr_addr,
    output logic [vfc_pkg::VALUE_W-1:0]    wr_data,
    output logic                           rd_en,
    output logic [AW-1:0]                  rd_addr,
    input  logic [vfc_pkg::VALUE_W-1:0]    rd_data,
    output logic [vfc_pkg::VALUE_W-1:0]    cmp_b,
    input  vfc_pkg::cmp_flags_t            cmp_flags
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_RD    = 3'd1;
    localparam logic [2:0] S_INS_CMP   = 3'd2;
    localparam logic [2:0] S_SCAN_RD   = 3'd3;
    localparam logic [2:0] S_SCAN_CHK  = 3'd4;
    localparam logic [2:0] S_EMIT_LAST = 3'd5;

    localparam logic [CW-1:0] FULL  = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] ONE   = CW'(1);

    logic [2:0]                    state_reg, state_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          drop_reg, drop_next;
    logic [CW-1:0]                 k_reg, k_next;
    logic [vfc_pkg::VALUE_W-1:0]   v_reg, v_next;
    logic                          last_pend_reg, last_pend_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [vfc_pkg::VALUE_W-1:0]   run_val_reg, run_val_next;
    logic [CW-1:0]                 run_cnt_reg, run_cnt_next;
    vfc_pkg::out_word_t            out_reg, out_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          out_free;
    logic                          out_load;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign cmp_b    = (state_reg == S_INS_CMP) ? v_reg : run_val_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        drop_next      = drop_reg;
        k_next         = k_reg;
        v_next         = v_reg;
        last_pend_next = last_pend_reg;
        idx_next       = idx_reg;
        run_val_next   = run_val_reg;
        run_cnt_next   = run_cnt_reg;
        out_next       = out_reg;
        out_load       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = k_reg[AW-1:0];
        wr_data        = v_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (cnt_reg < FULL) begin
                        v_next         = s_data.sample_value;
                        k_next         = cnt_reg;
                        last_pend_next = s_data.last_item;
                        state_next     = S_INS_RD;
                    end else begin
                        drop_next = 1'b1;
                        if (s_data.last_item) begin
                            idx_next     = '0;
                            run_cnt_next = '0;
                            state_next   = S_SCAN_RD;
                        end
                    end
                end
            end
            // Insertion keeps the store sorted: larger entries move up one place.
            S_INS_RD: begin
                if (k_reg == '0) begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + ONE;
                    if (last_pend_reg) begin
                        idx_next     = '0;
                        run_cnt_next = '0;
                        state_next   = S_SCAN_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = k_next[AW-1:0] - AW'(1);
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                wr_en = 1'b1;
                if (cmp_flags.gt) begin
                    wr_data    = rd_data;
                    k_next     = k_reg - ONE;
                    state_next = S_INS_RD;
                end else begin
                    cnt_next = cnt_reg + ONE;
                    if (last_pend_reg) begin
                        idx_next     = '0;
                        run_cnt_next = '0;
                        state_next   = S_SCAN_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SCAN_RD: begin
                rd_en      = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (run_cnt_reg == '0 || cmp_flags.eq) begin
                    run_val_next = rd_data;
                    run_cnt_next = run_cnt_reg + ONE;
                    idx_next     = idx_reg + ONE;
                    state_next   = (idx_reg + ONE == cnt_reg) ? S_EMIT_LAST : S_SCAN_RD;
                end else if (out_free) begin
                    // A new value closes the previous run.
                    out_load                = 1'b1;
                    out_next.distinct_value = run_val_reg;
                    out_next.occurrences    = vfc_pkg::OCC_W'(run_cnt_reg);
                    out_next.last_run       = 1'b0;
                    out_next.overflowed     = drop_reg;
                    run_val_next            = rd_data;
                    run_cnt_next            = ONE;
                    idx_next                = idx_reg + ONE;
                    state_next = (idx_reg + ONE == cnt_reg) ? S_EMIT_LAST : S_SCAN_RD;
                end
            end
            S_EMIT_LAST: begin
                if (out_free) begin
                    out_load                = 1'b1;
                    out_next.distinct_value = run_val_reg;
                    out_next.occurrences    = vfc_pkg::OCC_W'(run_cnt_reg);
                    out_next.last_run       = 1'b1;
                    out_next.overflowed     = drop_reg;
                    cnt_next                = '0;
                    drop_next               = 1'b0;
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
        k_reg         <= k_next;
        v_reg         <= v_next;
        last_pend_reg <= last_pend_next;
        idx_reg       <= idx_next;
        run_val_reg   <= run_val_next;
        run_cnt_reg   <= run_cnt_next;
        out_reg       <= out_next;
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FULL)
        else $error("stored count exceeds capacity");

    a_ins_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_CMP) |-> (k_reg != '0))
        else $error("insertion compare at position zero");

    a_set_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT_LAST && out_free) |=>
            (state_reg == S_IDLE && cnt_reg == '0 && !drop_reg && m_valid_reg))
        else $error("set end did not clear the store");

    a_occ_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_reg.occurrences != '0))
        else $error("result with zero occurrences");

endmodule

// File: design/value_frequency_counter_core.sv
// Channel  Ports                          Word type            Direction
// input    s_valid, s_ready, s_data       vfc_pkg::in_word_t   in
// result   m_valid, m_ready, m_data       vfc_pkg::out_word_t  out
//
// Each word is inserted into a sorted store by one shared comparator: an accepted word keeps
// s_ready low while each stored entry larger than it moves up one place, until it settles.
// A word with last_item then scans the store through one read port, entry by entry, and
// then emits the final result.
// A word that finds the store full is dropped.
// Reset (aresetn low, synchronous) empties the store; it needs no clearing pass.
// A result stalled on m_ready holds the scan, and s_ready stays low until the set ends.
module value_frequency_counter_core #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vfc_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vfc_pkg::out_word_t  m_data
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [vfc_pkg::VALUE_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [vfc_pkg::VALUE_W-1:0] rd_data;
    logic [vfc_pkg::VALUE_W-1:0] cmp_b;
    vfc_pkg::cmp_flags_t         cmp_flags;

    vfc_store #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    vfc_cmp u_cmp (
        .a     (rd_data),
        .b     (cmp_b),
        .flags (cmp_flags)
    );

    vfc_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .cmp_b     (cmp_b),
        .cmp_flags (cmp_flags)
    );

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic signed [vfc_pkg::VALUE_W-1:0] MAX_VALUE = 32'sh7fffffff;
    localparam logic signed [vfc_pkg::VALUE_W-1:0] MIN_VALUE = 32'sh80000000;

    typedef enum int {
        SPREAD_NARROW,
        SPREAD_EDGE,
        SPREAD_FULL,
        SPREAD_MIXED
    } spread_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    vfc_pkg::in_word_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    vfc_pkg::out_word_t m_data;

    // Predictor state: the elements of the open set, as the block should hold them.
    logic signed [vfc_pkg::VALUE_W-1:0] set_values [STORE_DEPTH];
    int                                 set_fill = 0;
    logic                               set_dropped = 1'b0;
    vfc_pkg::out_word_t                 expected_counts_q [$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int failures = 0;
    int words_sent = 0;
    int sets_sent = 0;
    int overflow_sets = 0;
    int results_checked = 0;
    int cycle_count = 0;
    vfc_pkg::out_word_t oldest_count;

    value_frequency_counter_core #(
        .MAX_ITEMS(STORE_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sort the collected set and queue one count per distinct value, ascending.
    task automatic predict_frequencies();
        logic signed [vfc_pkg::VALUE_W-1:0] sorted [STORE_DEPTH];
        logic signed [vfc_pkg::VALUE_W-1:0] key;
        vfc_pkg::out_word_t                 entry;
        int                                 i;
        int                                 j;
        int                                 run_len;
        for (i = 0; i < set_fill; i++) begin
            sorted[i] = set_values[i];
        end
        for (i = 1; i < set_fill; i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        i = 0;
        while (i < set_fill) begin
            run_len = 0;
            j = i;
            while (j < set_fill && sorted[j] == sorted[i]) begin
                run_len++;
                j++;
            end
            entry.distinct_value = sorted[i];
            entry.occurrences    = run_len[vfc_pkg::OCC_W-1:0];
            entry.last_run       = (j >= set_fill);
            entry.overflowed     = set_dropped;
            expected_counts_q.push_back(entry);
            i = j;
        end
        if (set_dropped) begin
            overflow_sets++;
        end
        sets_sent++;
        set_fill = 0;
        set_dropped = 1'b0;
    endtask

    task automatic record_word(input vfc_pkg::in_word_t w);
        if (set_fill < STORE_DEPTH) begin
            set_values[set_fill] = w.sample_value;
            set_fill++;
        end else begin
            set_dropped = 1'b1;
        end
        if (w.last_item) begin
            predict_frequencies();
        end
    endtask

    task automatic send_word(input logic signed [vfc_pkg::VALUE_W-1:0] value,
                             input logic last);
        vfc_pkg::in_word_t w;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        w.sample_value = value;
        w.last_item    = last;
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        record_word(w);
        words_sent++;
    endtask

    function automatic logic signed [vfc_pkg::VALUE_W-1:0] pick_value(input spread_t spread);
        spread_t mode;
        mode = spread;
        if (mode == SPREAD_MIXED) begin
            mode = spread_t'($urandom_range(2));
        end
        case (mode)
            SPREAD_NARROW: return int'($urandom_range(8)) - 4;
            SPREAD_EDGE: begin
                case ($urandom_range(3))
                    0: return MAX_VALUE;
                    1: return MIN_VALUE;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_set(input int size, input spread_t spread);
        for (int i = 0; i < size; i++) begin
            send_word(pick_value(spread), i == size - 1);
        end
    endtask

    task automatic set_idling(input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
    endtask

    task automatic wait_for_drain();
        while (expected_counts_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_single_element();
        send_word(5, 1'b1);
    endtask

    task automatic test_field_extremes();
        send_word(MAX_VALUE, 1'b0);
        send_word(MIN_VALUE, 1'b0);
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(1, 1'b0);
        send_word(MIN_VALUE, 1'b0);
        send_word(MAX_VALUE, 1'b0);
        send_word(32'sh55555555, 1'b0);
        send_word(32'shAAAAAAAA, 1'b1);
    endtask

    task automatic test_duplicate_runs();
        send_word(7, 1'b0);
        send_word(-7, 1'b0);
        send_word(7, 1'b0);
        send_word(7, 1'b0);
        send_word(-7, 1'b0);
        send_word(3, 1'b1);
    endtask

    task automatic test_equal_values();
        for (int i = 0; i < 4; i++) begin
            send_word(-1, i == 3);
        end
    endtask

    task automatic test_descending_order();
        for (int i = 4; i >= 0; i--) begin
            send_word(i, i == 0);
        end
    endtask

    // A full store of one value, then a dropped word and a dropped last word.
    task automatic test_store_full();
        for (int i = 0; i < STORE_DEPTH; i++) begin
            send_word(-100, 1'b0);
        end
        send_word(42, 1'b0);
        send_word(43, 1'b1);
    endtask

    // Exactly a full store of widely spread values: the longest result burst, no drop.
    task automatic test_max_results();
        send_random_set(STORE_DEPTH, SPREAD_FULL);
    endtask

    task automatic test_random_sets(input int budget);
        int start;
        int size;
        start = words_sent;
        while (words_sent - start < budget) begin
            case ($urandom_range(7))
                0: size = $urandom_range(10, 6);
                default: size = $urandom_range(4, 1);
            endcase
            send_random_set(size, spread_t'($urandom_range(3)));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_counts_q.size() == 0) begin
                $error("result word with no count pending: value %0d, occurrences %0d",
                       m_data.distinct_value, m_data.occurrences);
                failures++;
            end else begin
                oldest_count = expected_counts_q.pop_front();
                results_checked++;
                if (m_data.distinct_value !== oldest_count.distinct_value) begin
                    $error("distinct_value mismatch: expected %0d, got %0d",
                           oldest_count.distinct_value, m_data.distinct_value);
                    failures++;
                end
                if (m_data.occurrences !== oldest_count.occurrences) begin
                    $error("occurrences mismatch: expected %0d, got %0d",
                           oldest_count.occurrences, m_data.occurrences);
                    failures++;
                end
                if (m_data.last_run !== oldest_count.last_run) begin
                    $error("last_run mismatch: expected %0b, got %0b",
                           oldest_count.last_run, m_data.last_run);
                    failures++;
                end
                if (m_data.overflowed !== oldest_count.overflowed) begin
                    $error("overflowed mismatch: expected %0b, got %0b",
                           oldest_count.overflowed, m_data.overflowed);
                    failures++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        set_idling(0, 0);
        test_single_element();
        test_field_extremes();
        test_duplicate_runs();
        test_equal_values();
        test_descending_order();
        test_random_sets(4);

        set_idling(84, 0);
        test_random_sets(4);

        set_idling(0, 84);
        test_max_results();
        test_random_sets(4);

        set_idling(10, 10);
        test_store_full();
        test_random_sets(4);

        s_valid <= 1'b0;
        wait_for_drain();

        $display("Sent %0d words in %0d sets, %0d of them over capacity.",
                 words_sent, sets_sent, overflow_sets);
        $display("Checked %0d frequency results; %0d still pending.",
                 results_checked, expected_counts_q.size());
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
design/vfc_pkg.sv
design/vfc_store.sv
design/vfc_cmp.sv
design/vfc_ctrl.sv
design/value_frequency_counter_core.sv
tb/tb.sv
